@@ hdl/cfp_pkg.sv @@
// cfp_pkg: shared types and constants for the camera frame packetizer.
// Used by cfp_regs, cfp_ctrl, cfp_dp and camera_frame_packetizer.
package cfp_pkg;

  // Frame and packet header lengths in bytes
  localparam int HEADER_BYTES        = 14;
  localparam int PACKET_HEADER_BYTES = 4;

  // Frame size in bytes (up to 2048 * 2048 * 2) and divider steps
  localparam int TOTAL_W   = 24;
  localparam int DIV_STEPS = TOTAL_W;
  localparam int CNT_W     = 5;
  localparam int IDX_W     = 4;

  // Dimension saturation limit
  localparam logic [11:0] DIM_LIMIT = 12'd2048;

  // Configuration register indexes and reset values
  localparam logic [2:0] REG_SYNC_WORD  = 3'd0;
  localparam logic [2:0] REG_END_WORD   = 3'd1;
  localparam logic [2:0] REG_PIX_COLS   = 3'd2;
  localparam logic [2:0] REG_PIX_ROWS   = 3'd3;
  localparam logic [2:0] REG_CHUNK_SIZE = 3'd4;
  localparam int PADDR_W = 5;

  localparam logic [11:0] WIDTH_RST  = 12'd320;
  localparam logic [11:0] HEIGHT_RST = 12'd240;
  localparam logic [15:0] CHUNK_RST  = 16'd1024;

  // Byte source selected for the output register
  localparam logic [1:0] PH_FHDR = 2'd0;
  localparam logic [1:0] PH_PHDR = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;

  typedef struct packed {
    logic [15:0] sync_word;
    logic [15:0] end_word;
    logic [11:0] pix_cols;
    logic [11:0] pix_rows;
    logic [15:0] chunk_size;
  } cfp_cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic             load_in;
    logic             mul;
    logic             div_init;
    logic             div_step;
    logic             emit;
    logic [1:0]       phase;
    logic [IDX_W-1:0] idx;
    logic             last;
    logic             start_commit;
    logic             pkt_open;
    logic             pixel_commit;
  } cfp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic frame_active;
    logic chunk_zero;
    logic out_free;
  } cfp_stat_t;

endpackage

@@ hdl/cfp_regs.sv @@
// cfp_regs: APB-style configuration registers of the packetizer.
// Depends on cfp_pkg for register indexes, reset values and cfp_cfg_t.
module cfp_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cfp_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output cfp_pkg::cfp_cfg_t           cfg
);
  import cfp_pkg::*;

  cfp_cfg_t   cfg_r, cfg_nxt;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg     = cfg_r;

  // Register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_SYNC_WORD:  cfg_nxt.sync_word  = pwdata[15:0];
        REG_END_WORD:   cfg_nxt.end_word   = pwdata[15:0];
        REG_PIX_COLS:   cfg_nxt.pix_cols   = pwdata[11:0];
        REG_PIX_ROWS:   cfg_nxt.pix_rows   = pwdata[11:0];
        REG_CHUNK_SIZE: cfg_nxt.chunk_size = pwdata[15:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_word  <= 16'd0;
      cfg_r.end_word   <= 16'd0;
      cfg_r.pix_cols   <= WIDTH_RST;
      cfg_r.pix_rows   <= HEIGHT_RST;
      cfg_r.chunk_size <= CHUNK_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read mux
  always_comb begin
    case (reg_idx)
      REG_SYNC_WORD:  prdata = {16'd0, cfg_r.sync_word};
      REG_END_WORD:   prdata = {16'd0, cfg_r.end_word};
      REG_PIX_COLS:   prdata = {20'd0, cfg_r.pix_cols};
      REG_PIX_ROWS:   prdata = {20'd0, cfg_r.pix_rows};
      REG_CHUNK_SIZE: prdata = {16'd0, cfg_r.chunk_size};
      default:        prdata = 32'd0;
    endcase
  end

endmodule

@@ hdl/cfp_dp.sv @@
// cfp_dp: packetizer datapath: frame state, size multiplier, packet-count
// divider, header byte mux and output register. Depends on cfp_pkg.
module cfp_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  cfp_pkg::cfp_cfg_t  cfg,
  input  cfp_pkg::cfp_cmd_t  cmd,
  output cfp_pkg::cfp_stat_t stat,
  input  logic [7:0]         in_pixel_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic               out_packet_end,
  output logic               out_frame_end,
  output logic               out_run_last
);
  import cfp_pkg::*;

  // Frame state
  logic               frame_active_r, frame_active_nxt;
  logic [15:0]        frame_number_r, frame_number_nxt;
  logic [TOTAL_W-1:0] bytes_left_r, bytes_left_nxt;
  logic [15:0]        packet_number_r, packet_number_nxt;
  logic [15:0]        chunk_left_r, chunk_left_nxt;

  // Arithmetic payload
  logic [7:0]         pix_r;
  logic [22:0]        prod_r;
  logic [TOTAL_W-1:0] total_r;
  logic [TOTAL_W-1:0] quo_r;
  logic [15:0]        rem_r;

  // Output register
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       out_pe_r, out_fe_r, out_last_r;

  logic [11:0]        w_sat, h_sat;
  logic [23:0]        prod_full;
  logic [15:0]        eff_c;
  logic [TOTAL_W-1:0] total_full;
  logic [16:0]        trial, diff;
  logic               ge;
  logic [15:0]        len;
  logic [15:0]        cl_dec;
  logic [TOTAL_W-1:0] bl_dec;
  logic               pe, fe;
  logic [7:0]         sel_byte;
  logic               sel_pe, sel_fe;
  logic               out_free;

  // Size arithmetic
  assign w_sat      = (cfg.pix_cols > DIM_LIMIT) ? DIM_LIMIT : cfg.pix_cols;
  assign h_sat      = (cfg.pix_rows > DIM_LIMIT) ? DIM_LIMIT : cfg.pix_rows;
  assign prod_full  = w_sat * h_sat;
  assign eff_c      = (cfg.chunk_size == 16'd0) ? 16'd1 : cfg.chunk_size;
  assign total_full = {prod_r, 1'b0};

  // One restoring division step per cycle
  assign trial = {rem_r, quo_r[TOTAL_W-1]};
  assign ge    = (trial >= {1'b0, eff_c});
  assign diff  = trial - {1'b0, eff_c};

  // Packet length and data byte flags
  assign len    = (bytes_left_r < TOTAL_W'(eff_c)) ? bytes_left_r[15:0] : eff_c;
  assign cl_dec = chunk_left_r - 16'd1;
  assign bl_dec = bytes_left_r - TOTAL_W'(1);
  assign fe     = (bl_dec == '0);
  assign pe     = (cl_dec == 16'd0) | fe;

  always_ff @(posedge clk) begin
    if (cmd.load_in) pix_r <= in_pixel_byte;
    if (cmd.mul)     prod_r <= prod_full[22:0];
    if (cmd.div_init) begin
      total_r <= total_full;
      quo_r   <= total_full + TOTAL_W'(eff_c) - TOTAL_W'(1);
      rem_r   <= 16'd0;
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[TOTAL_W-2:0], ge};
      rem_r <= ge ? diff[15:0] : trial[15:0];
    end
  end

  // Byte select
  always_comb begin
    sel_byte = 8'd0;
    sel_pe   = 1'b0;
    sel_fe   = 1'b0;
    case (cmd.phase)
      PH_FHDR: begin
        case (cmd.idx)
          4'd0:    sel_byte = cfg.sync_word[15:8];
          4'd1:    sel_byte = cfg.sync_word[7:0];
          4'd2:    sel_byte = frame_number_r[7:0];
          4'd3:    sel_byte = frame_number_r[15:8];
          4'd4:    sel_byte = quo_r[7:0];
          4'd5:    sel_byte = quo_r[15:8];
          4'd6:    sel_byte = cfg.chunk_size[7:0];
          4'd7:    sel_byte = cfg.chunk_size[15:8];
          4'd8:    sel_byte = cfg.pix_cols[7:0];
          4'd9:    sel_byte = {4'd0, cfg.pix_cols[11:8]};
          4'd10:   sel_byte = cfg.pix_rows[7:0];
          4'd11:   sel_byte = {4'd0, cfg.pix_rows[11:8]};
          4'd12:   sel_byte = cfg.end_word[15:8];
          4'd13:   sel_byte = cfg.end_word[7:0];
          default: sel_byte = 8'd0;
        endcase
      end
      PH_PHDR: begin
        case (cmd.idx)
          4'd0:    sel_byte = packet_number_r[7:0];
          4'd1:    sel_byte = packet_number_r[15:8];
          4'd2:    sel_byte = len[7:0];
          4'd3:    sel_byte = len[15:8];
          default: sel_byte = 8'd0;
        endcase
      end
      PH_DATA: begin
        sel_byte = pix_r;
        sel_pe   = pe;
        sel_fe   = fe;
      end
      default: sel_byte = 8'd0;
    endcase
  end

  // Frame state update
  always_comb begin
    frame_active_nxt  = frame_active_r;
    frame_number_nxt  = frame_number_r;
    bytes_left_nxt    = bytes_left_r;
    packet_number_nxt = packet_number_r;
    chunk_left_nxt    = chunk_left_r;
    if (cmd.start_commit) begin
      bytes_left_nxt    = total_r;
      packet_number_nxt = 16'd0;
      chunk_left_nxt    = 16'd0;
      frame_active_nxt  = (total_r != '0);
      if (total_r == '0) frame_number_nxt = frame_number_r + 16'd1;
    end else if (cmd.pkt_open) begin
      chunk_left_nxt = len;
    end else if (cmd.pixel_commit) begin
      bytes_left_nxt = bl_dec;
      chunk_left_nxt = pe ? 16'd0 : cl_dec;
      if (pe) packet_number_nxt = packet_number_r + 16'd1;
      if (fe) begin
        frame_active_nxt = 1'b0;
        frame_number_nxt = frame_number_r + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_active_r  <= 1'b0;
      frame_number_r  <= 16'd0;
      bytes_left_r    <= '0;
      packet_number_r <= 16'd0;
      chunk_left_r    <= 16'd0;
    end else begin
      frame_active_r  <= frame_active_nxt;
      frame_number_r  <= frame_number_nxt;
      bytes_left_r    <= bytes_left_nxt;
      packet_number_r <= packet_number_nxt;
      chunk_left_r    <= chunk_left_nxt;
    end
  end

  // Output register
  assign out_free = ~out_valid_r | out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit)      out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
    if (cmd.emit) begin
      out_byte_r <= sel_byte;
      out_pe_r   <= sel_pe;
      out_fe_r   <= sel_fe;
      out_last_r <= cmd.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_packet_end = out_pe_r;
  assign out_frame_end  = out_fe_r;
  assign out_run_last   = out_last_r;

  assign stat.frame_active = frame_active_r;
  assign stat.chunk_zero   = (chunk_left_r == 16'd0);
  assign stat.out_free     = out_free;

  // An active frame always has bytes to come
  a_active_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    frame_active_r |-> (bytes_left_r != '0))
    else $error("frame active with no bytes left");

  // Open packet never outlasts the frame
  a_chunk_within_frame: assert property (@(posedge clk) disable iff (!rst_n)
    TOTAL_W'(chunk_left_r) <= bytes_left_r)
    else $error("packet remainder exceeds frame remainder");

  // A byte is loaded only into a free output register
  a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> out_free)
    else $error("output byte overwritten");

endmodule

@@ hdl/cfp_ctrl.sv @@
// cfp_ctrl: packetizer sequencer: input handshake, divider stepping and
// header/data byte emission. Depends on cfp_pkg.
module cfp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_mode,
  input  cfp_pkg::cfp_stat_t stat,
  output cfp_pkg::cfp_cmd_t  cmd
);
  import cfp_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_DINIT = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_FHDR  = 3'd4;
  localparam logic [2:0] S_PHDR  = 3'd5;
  localparam logic [2:0] S_DATA  = 3'd6;

  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIV_STEPS - 1);
  localparam logic [CNT_W-1:0] FHDR_LAST = CNT_W'(HEADER_BYTES - 1);
  localparam logic [CNT_W-1:0] PHDR_LAST = CNT_W'(PACKET_HEADER_BYTES - 1);

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid & in_ready;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.idx   = cnt_r[IDX_W-1:0];
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load_in = 1'b1;
          cnt_nxt     = '0;
          if (!in_mode)                state_nxt = S_MUL;
          else if (!stat.frame_active) state_nxt = S_IDLE;
          else if (stat.chunk_zero)    state_nxt = S_PHDR;
          else                         state_nxt = S_DATA;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DINIT;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == DIV_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_FHDR;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_FHDR: begin
        cmd.phase = PH_FHDR;
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (cnt_r == FHDR_LAST) begin
            cmd.last         = 1'b1;
            cmd.start_commit = 1'b1;
            state_nxt        = S_IDLE;
          end else begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
      end
      S_PHDR: begin
        cmd.phase = PH_PHDR;
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (cnt_r == PHDR_LAST) begin
            cmd.pkt_open = 1'b1;
            state_nxt    = S_DATA;
          end else begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
      end
      S_DATA: begin
        cmd.phase = PH_DATA;
        if (stat.out_free) begin
          cmd.emit         = 1'b1;
          cmd.last         = 1'b1;
          cmd.pixel_commit = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // A start item always goes to the size multiply
  a_start_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_mode) |=> (state_r == S_MUL))
    else $error("start item not sequenced");

  // Divider step count stays in range
  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (cnt_r <= DIV_LAST))
    else $error("divider step count out of range");

  // Header byte index stays in range
  a_hdr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FHDR) |-> (cnt_r <= FHDR_LAST))
    else $error("frame header index out of range");

endmodule

@@ hdl/camera_frame_packetizer.sv @@
// Camera frame packetizer: frames RGB565 pixel bytes into a byte stream with
// a 14-byte frame header and a 4-byte header in front of every packet. A
// start item (mode 0) is sequenced through a multiply of width by height, a
// divider setup and the bit-serial packet-count divider, then the frame
// header goes out one byte per cycle through the single output register,
// stalling while that register is not free. A pixel byte that opens a packet
// is preceded by the four packet header bytes; a pixel byte while no frame
// is active is taken and dropped. Configuration sits on an APB-style port,
// one 32-bit register per 4 bytes of address.
// Built from cfp_regs, cfp_ctrl and cfp_dp; depends on cfp_pkg.
module camera_frame_packetizer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_mode,
  input  logic [7:0]                  in_pixel_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_byte,
  output logic                        out_packet_end,
  output logic                        out_frame_end,
  output logic                        out_run_last,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cfp_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import cfp_pkg::*;

  cfp_cfg_t  cfg;
  cfp_cmd_t  cmd;
  cfp_stat_t stat;

  cfp_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cfp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_mode  (in_mode),
    .stat     (stat),
    .cmd      (cmd)
  );

  cfp_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .cmd            (cmd),
    .stat           (stat),
    .in_pixel_byte  (in_pixel_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_packet_end (out_packet_end),
    .out_frame_end  (out_frame_end),
    .out_run_last   (out_run_last)
  );

endmodule

@@ tb/camera_frame_packetizer_tb.sv @@
// Testbench for camera_frame_packetizer: drives start and pixel items, predicts the
// framed byte stream (frame headers, packet headers, data flags) and checks every result.
// Depends on cfp_pkg and the camera_frame_packetizer RTL.
`timescale 1ns / 1ps

module camera_frame_packetizer_tb;
  import cfp_pkg::*;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_PIXEL = 1'b1;
  localparam int SETTLE_CYCLES = 48;
  localparam int CYCLE_LIMIT = 600000;
  localparam int ITEM_TARGET = 170;
  localparam int PIXEL_CAP = 48;
  localparam int LONG_HOLD = 300;

  // One byte of the framed stream with its flags
  typedef struct packed {
    logic [7:0] data;
    logic       pkt_end;
    logic       frm_end;
    logic       run_last;
  } stream_beat_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_mode;
  logic [7:0]  in_pixel_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic        out_packet_end;
  logic        out_frame_end;
  logic        out_run_last;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Predictor state: register copy and frame progress
  cfp_cfg_t     cfg_shadow;
  logic         frame_live;
  logic [15:0]  frame_seq;
  logic [23:0]  bytes_remaining;
  logic [15:0]  packet_index;
  logic [15:0]  packet_room;
  stream_beat_t stream_expected[$];

  int unsigned mismatches = 0;
  int unsigned items_with_output = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_cycles = 0;
  bit          send_gaps = 1'b0;
  bit          sink_gaps = 1'b0;

  camera_frame_packetizer i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_pixel_byte  (in_pixel_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_packet_end (out_packet_end),
    .out_frame_end  (out_frame_end),
    .out_run_last   (out_run_last),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("camera_frame_packetizer verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    if (mismatches < 50)
      $display("MISMATCH at %0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Stream predictor
  // ---------------------------------------------------------------------------
  function automatic void push_beat(logic [7:0] data, logic pkt_end, logic frm_end);
    stream_beat_t b;
    b.data = data;
    b.pkt_end = pkt_end;
    b.frm_end = frm_end;
    b.run_last = 1'b0;
    stream_expected.push_back(b);
  endfunction

  function automatic void push_le16(logic [15:0] v);
    push_beat(v[7:0], 1'b0, 1'b0);
    push_beat(v[15:8], 1'b0, 1'b0);
  endfunction

  function automatic void push_be16(logic [15:0] v);
    push_beat(v[15:8], 1'b0, 1'b0);
    push_beat(v[7:0], 1'b0, 1'b0);
  endfunction

  // Appends the bytes one item produces; returns how many
  function automatic int predict_stream(logic mode, logic [7:0] pix);
    logic [11:0]  w_sat, h_sat;
    logic [31:0]  total, chunk_eff, pkts;
    logic [15:0]  len;
    logic         pkt_end, frm_end;
    stream_beat_t tail;
    int           start_size;
    start_size = stream_expected.size();
    chunk_eff = (cfg_shadow.chunk_size == 16'd0) ? 32'd1 : 32'(cfg_shadow.chunk_size);
    if (mode == MODE_START) begin
      w_sat = (cfg_shadow.pix_cols > DIM_LIMIT) ? DIM_LIMIT : cfg_shadow.pix_cols;
      h_sat = (cfg_shadow.pix_rows > DIM_LIMIT) ? DIM_LIMIT : cfg_shadow.pix_rows;
      total = 32'(w_sat) * 32'(h_sat) * 32'd2;
      pkts = (total + chunk_eff - 32'd1) / chunk_eff;
      push_be16(cfg_shadow.sync_word);
      push_le16(frame_seq);
      push_le16(pkts[15:0]);
      push_le16(cfg_shadow.chunk_size);
      push_le16(16'(cfg_shadow.pix_cols));
      push_le16(16'(cfg_shadow.pix_rows));
      push_be16(cfg_shadow.end_word);
      bytes_remaining = total[23:0];
      packet_index = 16'd0;
      packet_room = 16'd0;
      // an empty image completes at once
      if (total == 32'd0) begin
        frame_live = 1'b0;
        frame_seq = frame_seq + 16'd1;
      end else begin
        frame_live = 1'b1;
      end
    end else if (frame_live) begin
      // packet header in front of the byte that opens a packet
      if (packet_room == 16'd0) begin
        len = (32'(bytes_remaining) < chunk_eff) ? bytes_remaining[15:0] : chunk_eff[15:0];
        push_le16(packet_index);
        push_le16(len);
        packet_room = len;
      end
      packet_room = packet_room - 16'd1;
      bytes_remaining = bytes_remaining - 24'd1;
      pkt_end = (packet_room == 16'd0);
      frm_end = (bytes_remaining == 24'd0);
      if (frm_end)
        pkt_end = 1'b1;
      push_beat(pix, pkt_end, frm_end);
      if (pkt_end) begin
        packet_index = packet_index + 16'd1;
        packet_room = 16'd0;
      end
      if (frm_end) begin
        frame_live = 1'b0;
        frame_seq = frame_seq + 16'd1;
      end
    end
    if (stream_expected.size() > start_size) begin
      tail = stream_expected.pop_back();
      tail.run_last = 1'b1;
      stream_expected.push_back(tail);
    end
    return stream_expected.size() - start_size;
  endfunction

  // ---------------------------------------------------------------------------
  // Item sender, result sink and checker
  // ---------------------------------------------------------------------------
  task automatic send_item(logic mode, logic [7:0] pix);
    int unsigned gap;
    gap = send_gaps ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_pixel_byte <= pix;
    do @(posedge clk); while (!in_ready);
    if (predict_stream(mode, pix) > 0)
      items_with_output++;
  endtask

  // Ready with random gaps; a long hold when the pressure test asks for it
  initial begin : result_sink
    int unsigned gap;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      gap = sink_gaps ? $urandom_range(0, 18) : 0;
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        while (hold_cycles > 0) begin
          @(posedge clk);
          hold_cycles--;
        end
      end else if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin : result_check
    stream_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (stream_expected.size() == 0) begin
        report_mismatch("out_byte with nothing expected", out_byte, 0);
      end else begin
        want = stream_expected.pop_front();
        if (out_byte !== want.data)
          report_mismatch("out_byte", out_byte, want.data);
        if (out_packet_end !== want.pkt_end)
          report_mismatch("out_packet_end", out_packet_end, want.pkt_end);
        if (out_frame_end !== want.frm_end)
          report_mismatch("out_frame_end", out_frame_end, want.frm_end);
        if (out_run_last !== want.run_last)
          report_mismatch("out_run_last", out_run_last, want.run_last);
      end
    end
  end

  // Sender stops and waits until every expected byte has come out
  task automatic settle_block();
    in_valid <= 1'b0;
    while (stream_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] cfg_value(logic [2:0] idx);
    case (idx)
      REG_SYNC_WORD:  return 32'(cfg_shadow.sync_word);
      REG_END_WORD:   return 32'(cfg_shadow.end_word);
      REG_PIX_COLS:   return 32'(cfg_shadow.pix_cols);
      REG_PIX_ROWS:   return 32'(cfg_shadow.pix_rows);
      REG_CHUNK_SIZE: return 32'(cfg_shadow.chunk_size);
      default:        return 32'd0;
    endcase
  endfunction

  task automatic cfg_check(logic [2:0] idx);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== cfg_value(idx))
      report_mismatch("register readback", prdata, cfg_value(idx));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_SYNC_WORD:  cfg_shadow.sync_word = value[15:0];
      REG_END_WORD:   cfg_shadow.end_word = value[15:0];
      REG_PIX_COLS:   cfg_shadow.pix_cols = value[11:0];
      REG_PIX_ROWS:   cfg_shadow.pix_rows = value[11:0];
      REG_CHUNK_SIZE: cfg_shadow.chunk_size = value[15:0];
      default: ;
    endcase
    cfg_check(idx);
  endtask

  task automatic write_all_cfg(logic [15:0] sync_w, logic [15:0] end_w, logic [11:0] w,
                               logic [11:0] h, logic [15:0] chunk);
    cfg_write(REG_SYNC_WORD, 32'(sync_w));
    cfg_write(REG_END_WORD, 32'(end_w));
    cfg_write(REG_PIX_COLS, 32'(w));
    cfg_write(REG_PIX_ROWS, 32'(h));
    cfg_write(REG_CHUNK_SIZE, 32'(chunk));
  endtask

  function automatic logic [11:0] pick_dimension();
    case ($urandom_range(0, 19))
      0:       return 12'd0;
      1:       return DIM_LIMIT;
      2:       return 12'($urandom_range(2049, 4095));
      default: return 12'($urandom_range(1, 6));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values, pixels while idle, default frame and a restart mid-frame
  task automatic test_reset_state();
    cfg_check(REG_SYNC_WORD);
    cfg_check(REG_END_WORD);
    cfg_check(REG_PIX_COLS);
    cfg_check(REG_PIX_ROWS);
    cfg_check(REG_CHUNK_SIZE);
    send_item(MODE_PIXEL, 8'h00);
    send_item(MODE_PIXEL, 8'hFF);
    send_item(MODE_START, 8'h5A);
    send_item(MODE_PIXEL, 8'hFF);
    send_item(MODE_PIXEL, 8'h00);
    send_item(MODE_PIXEL, 8'hA5);
    // restart keeps the frame number
    send_item(MODE_START, 8'hFF);
    send_item(MODE_PIXEL, 8'h3C);
  endtask

  // Smallest frame: one packet of two bytes, then a dropped byte
  task automatic test_tiny_frame();
    settle_block();
    write_all_cfg(16'hFFFF, 16'h0000, 12'd1, 12'd1, 16'd2);
    sink_gaps = 1'b1;
    send_item(MODE_START, 8'h00);
    send_item(MODE_PIXEL, 8'h81);
    send_item(MODE_PIXEL, 8'h7E);
    send_item(MODE_PIXEL, 8'hC3);
  endtask

  // Zero width or height: header only, frame number advances
  task automatic test_empty_frames();
    settle_block();
    write_all_cfg(16'h1234, 16'hFEDC, 12'd0, 12'd5, 16'd4);
    send_item(MODE_START, 8'h11);
    settle_block();
    write_all_cfg(16'h1234, 16'hFEDC, 12'd3, 12'd0, 16'd4);
    send_item(MODE_START, 8'h22);
    send_item(MODE_PIXEL, 8'h33);
  endtask

  // Chunk size zero (one-byte packets) and an odd chunk size
  task automatic test_chunk_sizes();
    settle_block();
    write_all_cfg(16'hA5C3, 16'hFFFF, 12'd1, 12'd1, 16'd0);
    send_gaps = 1'b1;
    send_item(MODE_START, 8'h44);
    send_item(MODE_PIXEL, 8'h55);
    send_item(MODE_PIXEL, 8'hAA);
    settle_block();
    write_all_cfg(16'h0F0F, 16'hF0F0, 12'd2, 12'd1, 16'd3);
    send_item(MODE_START, 8'h66);
    repeat (4) send_item(MODE_PIXEL, 8'($urandom_range(0, 255)));
  endtask

  // Saturated dimensions and a packet count past 16 bits
  task automatic test_dimension_limits();
    settle_block();
    write_all_cfg(16'h8001, 16'h7FFE, 12'd4095, 12'd4095, 16'd1);
    send_item(MODE_START, 8'h01);
    send_item(MODE_PIXEL, 8'hFE);
    settle_block();
    write_all_cfg(16'hFFFF, 16'hFFFF, DIM_LIMIT, 12'd2049, 16'hFFFF);
    send_item(MODE_START, 8'h02);
    send_item(MODE_PIXEL, 8'hFD);
  endtask

  // Long output stall with the sender pushing, then a full pause mid-frame
  task automatic test_backpressure();
    settle_block();
    write_all_cfg(16'hCAFE, 16'hBEEF, 12'd4, 12'd4, 16'd6);
    send_gaps = 1'b0;
    sink_gaps = 1'b0;
    hold_cycles = LONG_HOLD;
    send_item(MODE_START, 8'h00);
    repeat (16) send_item(MODE_PIXEL, 8'($urandom_range(0, 255)));
    settle_block();
    repeat (16) send_item(MODE_PIXEL, 8'($urandom_range(0, 255)));
  endtask

  // Random settings; mostly complete frames, some cut short, some trailing noise
  task automatic test_random_frames();
    logic [11:0] w, h;
    logic [15:0] chunk;
    int unsigned n_frames, n_pix, style;
    while (items_with_output < ITEM_TARGET) begin
      settle_block();
      w = pick_dimension();
      h = pick_dimension();
      case ($urandom_range(0, 9))
        0:       chunk = 16'd0;
        1:       chunk = 16'd1;
        2:       chunk = 16'hFFFF;
        3:       chunk = 16'($urandom_range(3, 15)) | 16'd1;
        4:       chunk = 16'($urandom_range(0, 65535));
        default: chunk = 16'($urandom_range(1, 8)) << 1;
      endcase
      write_all_cfg(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), w, h,
                    chunk);
      send_gaps = ($urandom_range(0, 2) != 0);
      sink_gaps = ($urandom_range(0, 2) != 0);
      n_frames = $urandom_range(1, 3);
      repeat (n_frames) begin
        send_item(MODE_START, 8'($urandom_range(0, 255)));
        style = $urandom_range(0, 9);
        n_pix = bytes_remaining;
        if (n_pix > PIXEL_CAP)
          n_pix = $urandom_range(1, PIXEL_CAP);
        else if (style == 7 && n_pix > 0)
          n_pix = $urandom_range(0, n_pix - 1);
        repeat (n_pix) send_item(MODE_PIXEL, 8'($urandom_range(0, 255)));
        // stray bytes after the frame
        if (style >= 8)
          repeat ($urandom_range(1, 3)) send_item(MODE_PIXEL, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_mode <= MODE_START;
    in_pixel_byte <= 8'h00;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= 32'd0;
    cfg_shadow.sync_word = 16'd0;
    cfg_shadow.end_word = 16'd0;
    cfg_shadow.pix_cols = WIDTH_RST;
    cfg_shadow.pix_rows = HEIGHT_RST;
    cfg_shadow.chunk_size = CHUNK_RST;
    frame_live = 1'b0;
    frame_seq = 16'd0;
    bytes_remaining = 24'd0;
    packet_index = 16'd0;
    packet_room = 16'd0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_tiny_frame();
    test_empty_frames();
    test_chunk_sizes();
    test_dimension_limits();
    test_backpressure();
    test_random_frames();

    settle_block();
    if (mismatches == 0)
      $display("camera_frame_packetizer verification clean");
    else
      $display("camera_frame_packetizer verification failed");
    $finish;
  end

endmodule
